[hw/rtl/mra_pkg.sv]
package mra_pkg;

	// Fixed field and state widths
	localparam int SUM_W = 41;
	localparam int SQ_W  = 55;
	localparam int CNT_W = 25;
	localparam int OUT_W = 24;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 25'd16777216;

	// Opcodes
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_OK          = 2'd0;
	localparam logic [1:0] STAT_LIMIT       = 2'd1;
	localparam logic [1:0] STAT_NOT_RUNNING = 2'd2;
	localparam logic [1:0] STAT_RESULTS     = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [15:0] sample;
		logic               end_of_buffer;
	} in_word_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [OUT_W-1:0] average;
		logic [OUT_W-1:0]        rms;
		logic [CNT_W-1:0]        samples_taken;
		logic                    buffer_end;
	} out_word_t;

	// Accumulator contents seen by the finish engine
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sq;
		logic [CNT_W-1:0] count;
	} acc_view_t;

	// Immediate answer of the accumulator to the offered word
	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] samples_taken;
	} acc_resp_t;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_CALC,
		TS_LOAD
	} top_state_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_DIV_AVG,
		E_DIV_RMS,
		E_SQRT,
		E_DONE
	} eng_state_t;

endpackage

[hw/rtl/mra_accum.sv]
module mra_accum #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  mra_pkg::in_word_t            item,
	input  logic [mra_pkg::CNT_W-1:0]    sample_limit,
	output mra_pkg::acc_view_t           view,
	output mra_pkg::acc_resp_t           resp
);
	import mra_pkg::*;

	localparam int PROD_W = 2 * SAMPLE_BITS;
	localparam int LIM_W  = (COUNT_BITS + 1 > CNT_W) ? COUNT_BITS + 1 : CNT_W;

	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]  sq_q;
	logic [CNT_W-1:0] count_q;
	logic             running_q;

	logic [LIM_W-1:0]         cap;
	logic [LIM_W-1:0]         lim;
	logic [LIM_W-1:0]         lim_eff;
	logic                     full;
	logic signed [SAMPLE_BITS-1:0] smp;
	logic signed [PROD_W-1:0] prod;
	logic [SUM_W-1:0]         sum_add;
	logic [SQ_W-1:0]          sq_add;
	logic                     add_en;

	// Effective limit: register value saturated at the counter range
	assign cap     = LIM_W'(1) << COUNT_BITS;
	assign lim     = LIM_W'(sample_limit);
	assign lim_eff = (lim > cap) ? cap : lim;
	assign full    = LIM_W'(count_q) >= lim_eff;

	assign smp     = signed'(item.sample[SAMPLE_BITS-1:0]);
	assign prod    = smp * smp;
	assign sum_add = {{(SUM_W - SAMPLE_BITS){smp[SAMPLE_BITS-1]}}, smp};
	assign sq_add  = {{(SQ_W - PROD_W){1'b0}}, prod};

	assign add_en = (item.opcode == OP_SAMPLE) && running_q && !full;

	always_comb begin
		unique case (item.opcode)
			OP_START: begin
				resp.status        = STAT_OK;
				resp.samples_taken = '0;
			end
			OP_SAMPLE: begin
				if (!running_q) begin
					resp.status        = STAT_NOT_RUNNING;
					resp.samples_taken = count_q;
				end else if (full) begin
					resp.status        = STAT_LIMIT;
					resp.samples_taken = count_q;
				end else begin
					resp.status        = STAT_OK;
					resp.samples_taken = count_q + CNT_W'(1);
				end
			end
			OP_FINISH: begin
				resp.status        = STAT_RESULTS;
				resp.samples_taken = count_q;
			end
			default: begin
				resp.status        = STAT_NOT_RUNNING;
				resp.samples_taken = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			sq_q      <= '0;
			count_q   <= '0;
			running_q <= 1'b0;
		end else if (take) begin
			if (item.opcode == OP_START) begin
				sum_q     <= '0;
				sq_q      <= '0;
				count_q   <= '0;
				running_q <= 1'b1;
			end else if (item.opcode == OP_FINISH) begin
				running_q <= 1'b0;
			end else if (add_en) begin
				sum_q   <= sum_q + sum_add;
				sq_q    <= sq_q + sq_add;
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	assign view.sum   = sum_q;
	assign view.sq    = sq_q;
	assign view.count = count_q;

endmodule

[hw/rtl/mra_csub.sv]
module mra_csub #(
	parameter int W = 26
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         ge,
	output logic [W-1:0] diff
);
	logic borrow;

	// One subtractor gives both the compare and the difference
	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = !borrow;

endmodule

[hw/rtl/mra_engine.sv]
module mra_engine #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  mra_pkg::acc_view_t           view,
	output logic                         done,
	output logic [mra_pkg::OUT_W-1:0]    average,
	output logic [mra_pkg::OUT_W-1:0]    rms
);
	import mra_pkg::*;

	localparam int RT_W  = (SQ_W + 2 * FRACTION_BITS + 1) / 2;
	localparam int XW    = 2 * RT_W;
	localparam int SU_W  = (CNT_W + 1 > RT_W + 3) ? CNT_W + 1 : RT_W + 3;
	localparam int CTR_W = $clog2(XW);

	eng_state_t state_q, state_d;

	logic [XW-1:0]    sh_q;
	logic [SU_W-1:0]  rem_q;
	logic [RT_W-1:0]  root_q;
	logic [CTR_W-1:0] ctr_q;
	logic             neg_q;
	logic [OUT_W-1:0] avg_q;
	logic [OUT_W-1:0] rms_q;

	logic [SUM_W-1:0] mag;
	logic [SU_W-1:0]  op_a;
	logic [SU_W-1:0]  op_b;
	logic [SU_W-1:0]  diff;
	logic             ge;
	logic             last;
	logic [XW-1:0]    quo_next;
	logic [RT_W-1:0]  root_next;

	mra_csub #(.W(SU_W)) u_csub (
		.a    (op_a),
		.b    (op_b),
		.ge   (ge),
		.diff (diff)
	);

	assign mag       = view.sum[SUM_W-1] ? (~view.sum + 1'b1) : view.sum;
	assign last      = (ctr_q == '0);
	assign quo_next  = {sh_q[XW-2:0], ge};
	assign root_next = {root_q[RT_W-2:0], ge};

	// Operand select for the shared compare-subtract
	always_comb begin
		unique case (state_q)
			E_DIV_AVG, E_DIV_RMS: begin
				op_a = SU_W'({rem_q[CNT_W-1:0], sh_q[XW-1]});
				op_b = SU_W'(view.count);
			end
			E_SQRT: begin
				op_a = SU_W'({rem_q[RT_W:0], sh_q[XW-1 -: 2]});
				op_b = SU_W'({root_q, 2'b01});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			E_IDLE: begin
				if (start) begin
					state_d = (view.count == '0) ? E_DONE : E_DIV_AVG;
				end
			end
			E_DIV_AVG: begin
				if (last) begin
					state_d = E_DIV_RMS;
				end
			end
			E_DIV_RMS: begin
				if (last) begin
					state_d = E_SQRT;
				end
			end
			E_SQRT: begin
				if (last) begin
					state_d = E_DONE;
				end
			end
			E_DONE: begin
				state_d = E_IDLE;
			end
			default: begin
				state_d = E_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		done    = (state_q == E_DONE);
		average = avg_q;
		rms     = rms_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			E_IDLE: begin
				if (start) begin
					neg_q <= view.sum[SUM_W-1];
					sh_q  <= XW'(mag) << FRACTION_BITS;
					rem_q <= '0;
					ctr_q <= CTR_W'(XW - 1);
					if (view.count == '0) begin
						avg_q <= '0;
						rms_q <= '0;
					end
				end
			end
			E_DIV_AVG: begin
				if (last) begin
					avg_q <= neg_q ? (~quo_next[OUT_W-1:0] + 1'b1) : quo_next[OUT_W-1:0];
					// reload with the scaled sum of squares
					sh_q  <= XW'(view.sq) << (2 * FRACTION_BITS);
					rem_q <= '0;
					ctr_q <= CTR_W'(XW - 1);
				end else begin
					sh_q  <= quo_next;
					rem_q <= ge ? diff : op_a;
					ctr_q <= ctr_q - 1'b1;
				end
			end
			E_DIV_RMS: begin
				sh_q <= quo_next;
				if (last) begin
					rem_q  <= '0;
					root_q <= '0;
					ctr_q  <= CTR_W'(RT_W - 1);
				end else begin
					rem_q <= ge ? diff : op_a;
					ctr_q <= ctr_q - 1'b1;
				end
			end
			E_SQRT: begin
				rem_q  <= ge ? diff : op_a;
				root_q <= root_next;
				sh_q   <= {sh_q[XW-3:0], 2'b00};
				ctr_q  <= ctr_q - 1'b1;
				if (last) begin
					rms_q <= root_next[OUT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[hw/rtl/mean_rms_accumulator.sv]
// Mean and RMS of a stream of signed converter samples. A start word opens
// an acquisition and clears the running sum, the sum of squares and the
// count; each sample word inside a running acquisition is added to both
// sums until the configured sample limit (capped at 2**COUNT_BITS) is hit;
// a finish word closes the acquisition and reports the mean and the root
// mean square in fixed point with FRACTION_BITS fraction bits, both
// truncated. Every input word yields exactly one result word. Start and
// sample words can be accepted back to back while the result register
// drains. A finish word runs two restoring divisions and one
// digit-by-digit square root on a single shared compare-subtract unit,
// one quotient or root bit per cycle, with the divisions working on
// 55 + 2*FRACTION_BITS bits rounded up to even; meanwhile no new word is
// taken. sample_limit may only be written while the block is idle.
module mean_rms_accumulator #(
	parameter int SAMPLE_BITS   = 16,
	parameter int COUNT_BITS    = 24,
	parameter int FRACTION_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  mra_pkg::in_word_t            item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output mra_pkg::out_word_t           result,
	input  logic                         cfg_wen,
	input  logic [mra_pkg::CNT_W-1:0]    cfg_wdata
);
	import mra_pkg::*;

	top_state_t state_q, state_d;

	logic [CNT_W-1:0] sample_limit_q;
	logic             result_valid_q;
	out_word_t        result_q;
	out_word_t        result_d;
	logic             eob_q;

	logic             take;
	logic             out_free;
	logic             is_finish;
	logic             eng_start;
	logic             load_now;
	logic             eng_done;
	logic [OUT_W-1:0] eng_avg;
	logic [OUT_W-1:0] eng_rms;
	acc_view_t        view;
	acc_resp_t        resp;

	assign take      = item_valid && item_ready;
	assign out_free  = !result_valid_q || result_ready;
	assign is_finish = (item.opcode == OP_FINISH);

	mra_accum #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.item         (item),
		.sample_limit (sample_limit_q),
		.view         (view),
		.resp         (resp)
	);

	mra_engine #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (eng_start),
		.view    (view),
		.done    (eng_done),
		.average (eng_avg),
		.rms     (eng_rms)
	);

	// Next state: finish parks the front end until its report is loaded
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_IDLE: begin
				if (take && is_finish) begin
					state_d = TS_CALC;
				end
			end
			TS_CALC: begin
				if (eng_done) begin
					state_d = TS_LOAD;
				end
			end
			TS_LOAD: begin
				if (out_free) begin
					state_d = TS_IDLE;
				end
			end
			default: begin
				state_d = TS_IDLE;
			end
		endcase
	end

	// Handshake and load strobes
	always_comb begin
		item_ready = (state_q == TS_IDLE) && out_free;
		eng_start  = take && is_finish;
		load_now   = (take && !is_finish) || ((state_q == TS_LOAD) && out_free);
	end

	// Result word: report from the engine, or the immediate answer
	always_comb begin
		if (state_q == TS_LOAD) begin
			result_d.status        = STAT_RESULTS;
			result_d.average       = signed'(eng_avg);
			result_d.rms           = eng_rms;
			result_d.samples_taken = view.count;
			result_d.buffer_end    = eob_q;
		end else begin
			result_d.status        = resp.status;
			result_d.average       = '0;
			result_d.rms           = '0;
			result_d.samples_taken = resp.samples_taken;
			result_d.buffer_end    = item.end_of_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= TS_IDLE;
			result_valid_q <= 1'b0;
			sample_limit_q <= LIMIT_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				sample_limit_q <= cfg_wdata;
			end
			// hold the word until taken, then drop valid unless refilled
			if (load_now) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_now) begin
			result_q <= result_d;
		end
		if (eng_start) begin
			eob_q <= item.end_of_buffer;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
